FILE: rtl/jsb_pkg.sv
`default_nettype none
package jsb_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  localparam logic [6:0]  InflightReset = 7'd2;
  localparam logic [15:0] ReqLenReset = 16'd1024;
  localparam logic [15:0] RepLenReset = 16'd1024;
  localparam logic [31:0] FirstJobId = 32'd1;

  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    ACT_SUBMIT   = 3'd0,
    ACT_FETCH    = 3'd1,
    ACT_COMPLETE = 3'd2,
    ACT_POLL     = 3'd3,
    ACT_DESTROY  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    RC_OK    = 3'd0,
    RC_PERM  = 3'd1,
    RC_INVAL = 3'd2,
    RC_BUSY  = 3'd3,
    RC_NOENT = 3'd4,
    RC_NONE  = 3'd5
  } result_e;

  typedef enum logic [1:0] {
    PH_FREE = 2'd0,
    PH_PEND = 2'd1,
    PH_RUN  = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_INFLIGHT = 2'd0,
    CFG_REQ_LEN  = 2'd1,
    CFG_REP_LEN  = 2'd2
  } cfg_idx_e;

  // slot data kept in the RAM
  typedef struct packed {
    logic [31:0] owner_gen;
    logic [31:0] exec_gen;
    logic [15:0] payload_len;
  } slot_word_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [31:0] reply_job_id;
    logic [31:0] reply_owner;
    logic [15:0] reply_length;
    logic [1:0]  poll_state;
    logic        exec_status;
    logic [5:0]  slot_index;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/jsb_req_if.sv
`default_nettype none
interface jsb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] caller_pid;
  logic [31:0] caller_generation;
  logic        quota_ok;
  logic [31:0] job_ref;
  logic [15:0] request_length;
  logic        request_status;

  modport source(output valid, action, caller_pid, caller_generation, quota_ok, job_ref,
                 request_length, request_status, input ready);
  modport sink(input valid, action, caller_pid, caller_generation, quota_ok, job_ref,
               request_length, request_status, output ready);
endinterface
`default_nettype wire

FILE: rtl/jsb_rsp_if.sv
`default_nettype none
interface jsb_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic [31:0] reply_job_id;
  logic [31:0] reply_owner;
  logic [15:0] reply_length;
  logic [1:0]  poll_state;
  logic        exec_status;
  logic [5:0]  slot_index;

  modport source(output valid, result_code, reply_job_id, reply_owner, reply_length,
                 poll_state, exec_status, slot_index, input ready);
  modport sink(input valid, result_code, reply_job_id, reply_owner, reply_length,
               poll_state, exec_status, slot_index, output ready);
endinterface
`default_nettype wire

FILE: rtl/jsb_ram.sv
`default_nettype none
module jsb_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [Width-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AddrW-1:0]      raddr_i,
  output logic      [Width-1:0]      rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/job_slot_broker_top.sv
`default_nettype none
// Job-slot broker over a pool of jsb_pkg::SLOT_COUNT slots. One request word is taken at a
// time and gives exactly one reply word. Each request goes through two steps: a lookup step scans
// the per-slot phase, id and pid registers and issues the read of the chosen slot's RAM word
// (generations and payload length), and an execute step checks that word, writes it back and
// loads the reply register. A new request is taken the cycle after the reply is loaded, while
// that reply may still wait to be taken; the execute step holds only if the previous reply is
// still unclaimed. The slot RAM needs no clearing after reset. Configuration writes take
// effect at once and are meant for idle periods.
module job_slot_broker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  jsb_req_if.sink          req,
  jsb_rsp_if.source        rsp
);
  localparam int SlotN = jsb_pkg::SLOT_COUNT;
  localparam int CntW = jsb_pkg::CntW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0]  inflight_q;
  logic [15:0] req_lim_q, rep_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= jsb_pkg::InflightReset;
      req_lim_q  <= jsb_pkg::ReqLenReset;
      rep_lim_q  <= jsb_pkg::RepLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jsb_pkg::CFG_INFLIGHT: inflight_q <= cfg_data_i[6:0];
        jsb_pkg::CFG_REQ_LEN:  req_lim_q <= cfg_data_i;
        jsb_pkg::CFG_REP_LEN:  rep_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched request word
  logic [2:0]  act_q;
  logic [31:0] pid_q, gen_q, ref_q;
  logic        quota_q, st_q;
  logic [15:0] len_q;

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      act_q   <= req.action;
      pid_q   <= req.caller_pid;
      gen_q   <= req.caller_generation;
      quota_q <= req.quota_ok;
      ref_q   <= req.job_ref;
      len_q   <= req.request_length;
      st_q    <= req.request_status;
    end
  end

  // per-slot registers, of which the lookup scans phase, job id and owner
  jsb_pkg::phase_e phase_q [SlotN];
  jsb_pkg::phase_e phase_d [SlotN];
  logic            orphan_q [SlotN];
  logic            orphan_d [SlotN];
  logic            done_q [SlotN];
  logic            done_d [SlotN];
  logic [31:0]     job_id_q [SlotN];
  logic [31:0]     job_id_d [SlotN];
  logic [31:0]     owner_q [SlotN];
  logic [31:0]     owner_d [SlotN];
  logic [31:0]     exec_q [SlotN];
  logic [31:0]     exec_d [SlotN];
  logic [15:0]     res_len_q [SlotN];
  logic [15:0]     res_len_d [SlotN];
  logic [31:0]     next_id_q, next_id_d;

  // lookup decision
  jsb_pkg::result_e dec_rc, dec_rc_q;
  logic             dec_hit, dec_hit_q;
  jsb_pkg::slot_t   dec_slot, dec_slot_q;

  logic [CntW-1:0]  own_cnt;
  logic             free_f, pend_f, run_f, live_f;
  jsb_pkg::slot_t   free_i, pend_i, run_i, live_i;

  // scan the slots
  always_comb begin
    own_cnt = '0;
    free_f = 1'b0; free_i = '0;
    pend_f = 1'b0; pend_i = '0;
    run_f = 1'b0;  run_i = '0;
    live_f = 1'b0; live_i = '0;
    for (int i = 0; i < SlotN; i++) begin
      if (phase_q[i] != jsb_pkg::PH_FREE && owner_q[i] == pid_q) begin
        own_cnt = CntW'(own_cnt + 1'b1);
      end
      if (phase_q[i] == jsb_pkg::PH_PEND &&
          (!pend_f || job_id_q[i] < job_id_q[pend_i])) begin
        pend_f = 1'b1;
        pend_i = jsb_pkg::slot_t'(i);
      end
    end
    // lowest slot wins: walk downwards
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (phase_q[i] == jsb_pkg::PH_FREE) begin
        free_f = 1'b1;
        free_i = jsb_pkg::slot_t'(i);
      end
      if (phase_q[i] == jsb_pkg::PH_RUN && job_id_q[i] == ref_q) begin
        run_f = 1'b1;
        run_i = jsb_pkg::slot_t'(i);
      end
      if (phase_q[i] != jsb_pkg::PH_FREE && job_id_q[i] == ref_q) begin
        live_f = 1'b1;
        live_i = jsb_pkg::slot_t'(i);
      end
    end
  end

  // decide what the request does
  always_comb begin
    dec_rc = jsb_pkg::RC_OK;
    dec_hit = 1'b0;
    dec_slot = '0;
    case (act_q)
      jsb_pkg::ACT_SUBMIT: begin
        if (!quota_q) begin
          dec_rc = jsb_pkg::RC_PERM;
        end else if (len_q == 16'd0 || len_q > req_lim_q) begin
          dec_rc = jsb_pkg::RC_INVAL;
        end else if (7'(own_cnt) >= inflight_q || !free_f) begin
          dec_rc = jsb_pkg::RC_BUSY;
        end else begin
          dec_hit = 1'b1;
          dec_slot = free_i;
        end
      end
      jsb_pkg::ACT_FETCH: begin
        if (pend_f) begin
          dec_hit = 1'b1;
          dec_slot = pend_i;
        end else begin
          dec_rc = jsb_pkg::RC_NONE;
        end
      end
      jsb_pkg::ACT_COMPLETE: begin
        if (len_q > rep_lim_q) begin
          dec_rc = jsb_pkg::RC_INVAL;
        end else if (run_f) begin
          dec_hit = 1'b1;
          dec_slot = run_i;
        end else begin
          dec_rc = jsb_pkg::RC_NOENT;
        end
      end
      jsb_pkg::ACT_POLL: begin
        if (live_f) begin
          dec_hit = 1'b1;
          dec_slot = live_i;
        end else begin
          dec_rc = jsb_pkg::RC_NOENT;
        end
      end
      jsb_pkg::ACT_DESTROY: dec_rc = jsb_pkg::RC_OK;
      default: dec_rc = jsb_pkg::RC_INVAL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      dec_rc_q   <= dec_rc;
      dec_hit_q  <= dec_hit;
      dec_slot_q <= dec_slot;
    end
  end

  // slot RAM
  jsb_pkg::slot_word_t rd_word, wr_word;
  logic                ram_we;

  jsb_ram #(
    .Width($bits(jsb_pkg::slot_word_t)),
    .Depth(SlotN)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(dec_slot_q),
    .wdata_i(wr_word),
    .re_i   (state_q == ST_LOOK),
    .raddr_i(dec_slot),
    .rdata_o(rd_word)
  );

  // execute: check, modify, write back
  logic         out_valid_q;
  jsb_pkg::rsp_t out_q, out_d;
  logic         fire;

  assign fire = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

  always_comb begin
    phase_d = phase_q;
    orphan_d = orphan_q;
    done_d = done_q;
    job_id_d = job_id_q;
    owner_d = owner_q;
    exec_d = exec_q;
    res_len_d = res_len_q;
    next_id_d = next_id_q;
    wr_word = rd_word;
    ram_we = 1'b0;
    out_d = '0;
    out_d.result_code = dec_rc_q;
    if (fire && dec_hit_q) begin
      case (act_q)
        jsb_pkg::ACT_SUBMIT: begin
          phase_d[dec_slot_q] = jsb_pkg::PH_PEND;
          job_id_d[dec_slot_q] = next_id_q;
          owner_d[dec_slot_q] = pid_q;
          wr_word.owner_gen = gen_q;
          wr_word.payload_len = len_q;
          ram_we = 1'b1;
          next_id_d = (next_id_q == '1) ? jsb_pkg::FirstJobId : 32'(next_id_q + 32'd1);
          out_d.reply_job_id = next_id_q;
          out_d.slot_index = 6'(dec_slot_q);
        end
        jsb_pkg::ACT_FETCH: begin
          phase_d[dec_slot_q] = jsb_pkg::PH_RUN;
          exec_d[dec_slot_q] = pid_q;
          wr_word.exec_gen = gen_q;
          ram_we = 1'b1;
          out_d.reply_job_id = job_id_q[dec_slot_q];
          out_d.reply_owner = owner_q[dec_slot_q];
          out_d.reply_length = rd_word.payload_len;
          out_d.slot_index = 6'(dec_slot_q);
        end
        jsb_pkg::ACT_COMPLETE: begin
          out_d.slot_index = 6'(dec_slot_q);
          if (exec_q[dec_slot_q] != pid_q || rd_word.exec_gen != gen_q) begin
            out_d.result_code = jsb_pkg::RC_PERM;
          end else if (orphan_q[dec_slot_q]) begin
            phase_d[dec_slot_q] = jsb_pkg::PH_FREE;
            orphan_d[dec_slot_q] = 1'b0;
          end else begin
            phase_d[dec_slot_q] = jsb_pkg::PH_DONE;
            done_d[dec_slot_q] = st_q;
            res_len_d[dec_slot_q] = len_q;
          end
        end
        jsb_pkg::ACT_POLL: begin
          if (owner_q[dec_slot_q] != pid_q || rd_word.owner_gen != gen_q) begin
            out_d.result_code = jsb_pkg::RC_NOENT;
          end else begin
            out_d.reply_job_id = job_id_q[dec_slot_q];
            out_d.poll_state = phase_q[dec_slot_q];
            out_d.slot_index = 6'(dec_slot_q);
            if (phase_q[dec_slot_q] == jsb_pkg::PH_DONE) begin
              out_d.reply_length = res_len_q[dec_slot_q];
              out_d.exec_status = done_q[dec_slot_q];
              phase_d[dec_slot_q] = jsb_pkg::PH_FREE;
              orphan_d[dec_slot_q] = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
    // sweep every slot for the dying process
    if (fire && act_q == jsb_pkg::ACT_DESTROY) begin
      for (int i = 0; i < SlotN; i++) begin
        if (phase_q[i] != jsb_pkg::PH_FREE) begin
          if (owner_q[i] == pid_q) begin
            if (phase_q[i] == jsb_pkg::PH_RUN) begin
              orphan_d[i] = 1'b1;
            end else begin
              phase_d[i] = jsb_pkg::PH_FREE;
              orphan_d[i] = 1'b0;
            end
          end else if (exec_q[i] == pid_q && phase_q[i] == jsb_pkg::PH_RUN) begin
            if (orphan_q[i]) begin
              phase_d[i] = jsb_pkg::PH_FREE;
              orphan_d[i] = 1'b0;
            end else begin
              phase_d[i] = jsb_pkg::PH_DONE;
              done_d[i] = 1'b1;
              res_len_d[i] = 16'd0;
            end
          end
        end
      end
    end
  end

  // slot control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotN; i++) begin
        phase_q[i] <= jsb_pkg::PH_FREE;
        orphan_q[i] <= 1'b0;
      end
      next_id_q <= jsb_pkg::FirstJobId;
    end else begin
      phase_q <= phase_d;
      orphan_q <= orphan_d;
      next_id_q <= next_id_d;
    end
  end

  // slot payload registers
  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    job_id_q <= job_id_d;
    owner_q <= owner_d;
    exec_q <= exec_d;
    res_len_q <= res_len_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req.valid) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req.ready = (state_q == ST_IDLE);

  // reply register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.result_code  = out_q.result_code;
  assign rsp.reply_job_id = out_q.reply_job_id;
  assign rsp.reply_owner  = out_q.reply_owner;
  assign rsp.reply_length = out_q.reply_length;
  assign rsp.poll_state   = out_q.poll_state;
  assign rsp.exec_status  = out_q.exec_status;
  assign rsp.slot_index   = out_q.slot_index;
endmodule
`default_nettype wire

FILE: rtl/jsb_checker.sv
`default_nettype none
module jsb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [2:0]  result_code_i,
  input wire logic [31:0] reply_job_id_i,
  input wire logic [31:0] reply_owner_i,
  input wire logic [1:0]  poll_state_i
);
  // hold a stalled reply
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(result_code_i) && $stable(reply_job_id_i))
    else $error("stalled reply changed");

  // a failed call names no job
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && result_code_i != jsb_pkg::RC_OK |->
      reply_job_id_i == 32'd0 && reply_owner_i == 32'd0 && poll_state_i == 2'd0)
    else $error("failed reply carries job data");

  // a polled state always comes with a live job id
  a_poll_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && poll_state_i != 2'd0 |-> reply_job_id_i != 32'd0)
    else $error("poll state without job id");

  // an owner is only reported on a fetch, never with a poll state
  a_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && reply_owner_i != 32'd0 |-> poll_state_i == 2'd0 && reply_job_id_i != 32'd0)
    else $error("owner reported outside a fetch");
endmodule

bind job_slot_broker_top jsb_checker u_jsb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .result_code_i (rsp.result_code),
  .reply_job_id_i(rsp.reply_job_id),
  .reply_owner_i (rsp.reply_owner),
  .poll_state_i  (rsp.poll_state)
);
`default_nettype wire
